// ----- rtl/core/bst_pkg.sv -----
package bst_pkg;

  localparam int TABLE_DEPTH     = 16;
  localparam int MAX_FRAME_BYTES = 2048;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int LEN_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int SUM_W = IDX_W + 1;

  localparam logic [1:0] OP_OBSERVE = 2'd0;
  localparam logic [1:0] OP_FLUSH   = 2'd1;
  localparam logic [1:0] OP_DUMP    = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic [47:0] station_id;
    logic [63:0] seen_time;
    logic [15:0] frame_len;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  slot;
    logic        hit;
    logic        evicted;
    logic        truncated;
    logic [47:0] entry_station;
    logic [63:0] entry_time;
    logic [11:0] entry_length;
    logic [4:0]  fill;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [47:0]      key;
    logic [63:0]      stamp;
    logic [LEN_W-1:0] len;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
  } ram_req_t;

  // Map a logical slot onto the circular buffer that starts at base.
  function automatic logic [IDX_W-1:0] slot_wrap(input logic [IDX_W-1:0] base,
                                                 input logic [IDX_W-1:0] ofs);
    logic [SUM_W-1:0] sum;
    sum = {1'b0, base} + {1'b0, ofs};
    if (sum >= SUM_W'(TABLE_DEPTH)) begin
      sum = sum - SUM_W'(TABLE_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

// ----- rtl/core/bss_table_fifo_replace_top.sv -----
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_ready  | in_data  (op, station_id, seen_time, frame_len)
// out     | output    | out_valid/out_ready| out_data (slot ... fill, last)
//
// Observe reads and compares entries one at a time (S_RD, S_CMP), then writes (S_WR);
// the table RAM has one read port with a registered read, so every compare waits on it.
// Dump reads and lists each entry in turn; flush and an unused op do not read the RAM.
// Entries sit in a circular buffer, so eviction overwrites the head entry and advances the head.
// Reset (rst_n low, synchronous) empties the table; the RAM itself is not cleared.
// A stalled out_ready holds the result register and the controller waits on it.
module bss_table_fifo_replace_top
  import bst_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic      out_valid_r;
  out_item_t out_data_r;
  logic      out_free;
  logic      out_load;
  out_item_t out_item;
  ram_req_t  ram_req;
  entry_t    rd_data;

  assign out_free = !out_valid_r || out_ready;

  bst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_free (out_free),
    .out_load (out_load),
    .out_item (out_item),
    .ram_req  (ram_req),
    .rd_data  (rd_data)
  );

  bst_table_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (out_load) begin
      out_data_r <= out_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/core/bst_table_ram.sv -----
module bst_table_ram
  import bst_pkg::*;
(
  input  logic     clk,
  input  ram_req_t req,
  output entry_t   rd_data
);

  entry_t mem [TABLE_DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/core/bst_ctrl.sv -----
module bst_ctrl
  import bst_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_free,
  output logic      out_load,
  output out_item_t out_item,
  output ram_req_t  ram_req,
  input  entry_t    rd_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;
  localparam logic [2:0] S_CMP   = 3'd2;
  localparam logic [2:0] S_WR    = 3'd3;
  localparam logic [2:0] S_DUMP  = 3'd4;
  localparam logic [2:0] S_FLUSH = 3'd5;

  logic [2:0]       state_r, state_nxt;
  in_item_t         req_r, req_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic             hit_r, hit_nxt;

  logic             sat;
  logic [LEN_W-1:0] sat_len;
  logic             dump_last;

  assign sat       = req_r.frame_len > 16'(MAX_FRAME_BYTES);
  assign sat_len   = sat ? LEN_W'(MAX_FRAME_BYTES) : LEN_W'(req_r.frame_len);
  assign dump_last = (idx_r + CNT_W'(1)) == count_r;
  assign in_ready  = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    req_nxt   = req_r;
    idx_nxt   = idx_r;
    count_nxt = count_r;
    head_nxt  = head_r;
    hit_nxt   = hit_r;
    out_load  = 1'b0;
    out_item  = '0;
    ram_req   = '0;
    ram_req.wdata.key   = req_r.station_id;
    ram_req.wdata.stamp = req_r.seen_time;
    ram_req.wdata.len   = sat_len;
    ram_req.rd_addr     = slot_wrap(head_r, idx_r[IDX_W-1:0]);

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt = in_data;
          idx_nxt = '0;
          hit_nxt = 1'b0;
          case (in_data.op)
            OP_OBSERVE: state_nxt = (count_r == '0) ? S_WR : S_RD;
            OP_FLUSH:   state_nxt = S_FLUSH;
            OP_DUMP:    state_nxt = (count_r == '0) ? S_IDLE : S_RD;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_RD: begin
        ram_req.rd_en = 1'b1;
        state_nxt = (req_r.op == OP_DUMP) ? S_DUMP : S_CMP;
      end
      S_CMP: begin
        if (rd_data.key == req_r.station_id) begin
          hit_nxt   = 1'b1;
          state_nxt = S_WR;
        end else if (dump_last) begin
          state_nxt = S_WR;
        end else begin
          idx_nxt   = idx_r + CNT_W'(1);
          state_nxt = S_RD;
        end
      end
      S_WR: begin
        if (out_free) begin
          ram_req.we             = 1'b1;
          out_load               = 1'b1;
          out_item.hit           = hit_r;
          out_item.truncated     = sat;
          out_item.entry_station = req_r.station_id;
          out_item.entry_time    = req_r.seen_time;
          out_item.entry_length  = 12'(sat_len);
          out_item.last          = 1'b1;
          if (hit_r) begin
            ram_req.waddr = slot_wrap(head_r, idx_r[IDX_W-1:0]);
            out_item.slot = 4'(idx_r);
          end else if (count_r < CNT_W'(TABLE_DEPTH)) begin
            ram_req.waddr = slot_wrap(head_r, count_r[IDX_W-1:0]);
            out_item.slot = 4'(count_r);
            count_nxt     = count_r + CNT_W'(1);
          end else begin
            // overwrite the oldest entry and advance the head
            ram_req.waddr    = head_r;
            head_nxt         = slot_wrap(head_r, IDX_W'(1));
            out_item.slot    = 4'(TABLE_DEPTH - 1);
            out_item.evicted = 1'b1;
          end
          out_item.fill = 5'(count_nxt);
          state_nxt     = S_IDLE;
        end
      end
      S_DUMP: begin
        if (out_free) begin
          out_load               = 1'b1;
          out_item.slot          = 4'(idx_r);
          out_item.entry_station = rd_data.key;
          out_item.entry_time    = rd_data.stamp;
          out_item.entry_length  = 12'(rd_data.len);
          out_item.fill          = 5'(count_r);
          out_item.last          = dump_last;
          if (dump_last) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + CNT_W'(1);
            state_nxt = S_RD;
          end
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_item.last = 1'b1;
          count_nxt     = '0;
          head_nxt      = '0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      head_r  <= '0;
      idx_r   <= '0;
      hit_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      head_r  <= head_nxt;
      idx_r   <= idx_nxt;
      hit_r   <= hit_nxt;
    end
    req_r <= req_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && out_item.evicted |-> out_item.fill == 5'(TABLE_DEPTH))
    else $error("eviction without a full table");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> !(out_item.hit && out_item.evicted))
    else $error("hit and eviction in one result");

  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && state_r == S_FLUSH |=> count_r == '0 && head_r == '0)
    else $error("flush left entries behind");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_req.we && ram_req.rd_en))
    else $error("table read and write in one cycle");

endmodule
